// ----- rtl/core/mvga_pkg.sv -----
package mvga_pkg;

    // item modes
    localparam logic [1:0] MODE_VECTOR = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W            = 3;
    localparam logic [2:0] CFG_MIN_MOVE_SQ      = 3'd0;
    localparam logic [2:0] CFG_MAX_MOVE_SQ      = 3'd1;
    localparam logic [2:0] CFG_MIN_VECTOR_COUNT = 3'd2;
    localparam logic [2:0] CFG_REF_VALUE        = 3'd3;
    localparam logic [2:0] CFG_BUCKET_COLS      = 3'd4;
    localparam logic [2:0] CFG_BUCKET_ROWS      = 3'd5;

    // configuration reset values
    localparam logic [31:0] RST_MIN_MOVE_SQ      = 32'd4;
    localparam logic [31:0] RST_MAX_MOVE_SQ      = 32'd512000;
    localparam logic [15:0] RST_MIN_VECTOR_COUNT = 16'd2;
    localparam logic [15:0] RST_REF_VALUE        = 16'd16;
    localparam logic [6:0]  RST_BUCKET_COLS      = 7'd20;
    localparam logic [6:0]  RST_BUCKET_ROWS      = 7'd15;

    // grid limits and accumulator saturation
    localparam logic [6:0]  GRID_MAX  = 7'd64;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [23:0] SUM_MAX   = 24'h7FFFFF;
    localparam logic [23:0] SUM_MIN   = 24'h800000;

    // score datapath widths
    localparam int MAG_W       = 48;
    localparam int NUM_W       = 58;
    localparam int WEIGHT_FRAC = 8;
    localparam int DVD_W       = NUM_W - WEIGHT_FRAC;
    localparam int DVS_W       = 17;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic signed [15:0] vec_dx;
        logic signed [15:0] vec_dy;
        logic [11:0]        bkt_sel;
        logic [9:0]         mask_weight;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        hit;
        logic [31:0] score;
        logic [15:0] vector_count;
    } result_t;

    // one bucket word in the RAM
    typedef struct packed {
        logic [9:0]  weight;
        logic [15:0] count;
        logic [23:0] sum_x;
        logic [23:0] sum_y;
    } bucket_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_RMW,
        ST_SQ,
        ST_MAG,
        ST_NUM,
        ST_DIVGO,
        ST_DIV
    } state_t;

endpackage

// ----- rtl/core/mvga_ram.sv -----
module mvga_ram #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mvga_div.sv -----
module mvga_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mvga_pkg::DVD_W-1:0]  dividend,
    input  logic [mvga_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [mvga_pkg::DVD_W-1:0]  quotient
);

    logic                              run_reg;
    logic                              done_reg;
    logic [mvga_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [mvga_pkg::DVD_W-1:0]        shf_reg;
    logic [mvga_pkg::DVS_W-1:0]        rem_reg;
    logic [mvga_pkg::DVS_W-1:0]        dvs_reg;
    logic [mvga_pkg::DVS_W:0]          trial;
    logic [mvga_pkg::DVS_W:0]          diff;
    logic                              qbit;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, shf_reg[mvga_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    // control: iteration counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= mvga_pkg::DIV_CNT_W'(mvga_pkg::DVD_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == mvga_pkg::DIV_CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shf_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            shf_reg <= {shf_reg[mvga_pkg::DVD_W-2:0], qbit};
            rem_reg <= qbit ? diff[mvga_pkg::DVS_W-1:0] : trial[mvga_pkg::DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

// ----- rtl/core/motion_vector_grid_accumulator_core.sv -----
// vector, weight load and idle modes: result strobe registered from RMW after CALC and ADDR; next start that cycle
// read-and-clear: after RMW the item goes on through SQ, MAG, NUM, DIVGO and the one-bit-a-cycle divider
// one item at a time: start is taken only in idle, so busy stays high until the result strobe
// reset: clearing pass over all MAX_BUCKETS words of the bucket RAM (4096 by default) with busy high;
// configuration writes are taken during the pass
// results are strobed for one cycle; the receiver cannot stall
module motion_vector_grid_accumulator_core #(
    parameter int MAX_BUCKETS = 4096,
    parameter int BUCKET_BITS = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mvga_pkg::item_t                    item,
    output logic                               result_valid,
    output mvga_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mvga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_BUCKETS);
    localparam int THR_SHIFT = 2 * BUCKET_BITS - 3;

    // configuration registers
    logic [31:0] min_move_sq_reg;
    logic [31:0] max_move_sq_reg;
    logic [15:0] min_vector_count_reg;
    logic [15:0] ref_value_reg;
    logic [6:0]  bucket_cols_reg;
    logic [6:0]  bucket_rows_reg;

    // control state
    mvga_pkg::state_t  state_reg;
    mvga_pkg::state_t  state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    mvga_pkg::result_t result_reg;
    mvga_pkg::result_t result_next;

    // payload registers
    mvga_pkg::item_t                item_reg;
    logic [31:0]                    sq_x_reg;
    logic [31:0]                    sq_y_reg;
    logic [5:0]                     bx_reg;
    logic [5:0]                     by_reg;
    logic                           vec_ok_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic [23:0]                    sx_reg;
    logic [23:0]                    sy_reg;
    logic [9:0]                     wt_reg;
    logic [15:0]                    cnt_reg;
    logic [mvga_pkg::MAG_W-1:0]     msq_x_reg;
    logic [mvga_pkg::MAG_W-1:0]     msq_y_reg;
    logic [mvga_pkg::MAG_W-1:0]     mag_reg;
    logic [mvga_pkg::NUM_W-1:0]     num_reg;

    // combinational helpers
    logic [15:0]                    mx_u;
    logic [15:0]                    my_u;
    logic [15:0]                    mx_abs;
    logic [15:0]                    my_abs;
    logic [6:0]                     cols;
    logic [6:0]                     rows;
    logic [31:0]                    mot;
    logic                           in_window;
    logic [12:0]                    grid_idx;
    logic [31:0]                    grid_wide;
    logic [31:0]                    idx_wide;
    logic                           grid_ok;
    logic                           idx_ok;
    logic [ADDR_W-1:0]              rd_addr;
    logic [23:0]                    sx_abs;
    logic [23:0]                    sy_abs;
    logic [31:0]                    thr;
    mvga_pkg::bucket_t              rd;
    mvga_pkg::bucket_t              upd;

    // RAM and divider hookup
    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    mvga_pkg::bucket_t              ram_wdata;
    logic                           ram_re;
    logic                           div_start;
    logic                           div_done;
    logic [mvga_pkg::DVD_W-1:0]     div_quo;
    logic [mvga_pkg::DVS_W-1:0]     div_dvs;

    function automatic logic [5:0] clamp_axis(input logic [15:0] p, input logic [6:0] dim);
        logic [14:0] b;
        logic [6:0]  lim;
        lim = dim - 7'd1;
        b   = p[14:0] >> BUCKET_BITS;
        if (p[15])
        begin
            return 6'd0;
        end
        else if (b > 15'(lim))
        begin
            return lim[5:0];
        end
        else
        begin
            return b[5:0];
        end
    endfunction

    function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        s = {a[23], a} + {{9{b[15]}}, b};
        if (s[24] != s[23])
        begin
            return s[24] ? mvga_pkg::SUM_MIN : mvga_pkg::SUM_MAX;
        end
        else
        begin
            return s[23:0];
        end
    endfunction

    // bucket store: weight, count and sums in one word
    mvga_ram #(
        .WIDTH($bits(mvga_pkg::bucket_t)),
        .DEPTH(MAX_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (rd)
    );

    // score divider
    mvga_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg[mvga_pkg::NUM_W-1:mvga_pkg::WEIGHT_FRAC]),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_move_sq_reg      <= mvga_pkg::RST_MIN_MOVE_SQ;
            max_move_sq_reg      <= mvga_pkg::RST_MAX_MOVE_SQ;
            min_vector_count_reg <= mvga_pkg::RST_MIN_VECTOR_COUNT;
            ref_value_reg        <= mvga_pkg::RST_REF_VALUE;
            bucket_cols_reg      <= mvga_pkg::RST_BUCKET_COLS;
            bucket_rows_reg      <= mvga_pkg::RST_BUCKET_ROWS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mvga_pkg::CFG_MIN_MOVE_SQ:      min_move_sq_reg      <= cfg_data;
                mvga_pkg::CFG_MAX_MOVE_SQ:      max_move_sq_reg      <= cfg_data;
                mvga_pkg::CFG_MIN_VECTOR_COUNT: min_vector_count_reg <= cfg_data[15:0];
                mvga_pkg::CFG_REF_VALUE:        ref_value_reg        <= cfg_data[15:0];
                mvga_pkg::CFG_BUCKET_COLS:      bucket_cols_reg      <= cfg_data[6:0];
                mvga_pkg::CFG_BUCKET_ROWS:      bucket_rows_reg      <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // vector length, grid position and address selection
    always_comb
    begin
        mx_u   = item_reg.vec_dx;
        my_u   = item_reg.vec_dy;
        mx_abs = mx_u[15] ? (16'd0 - mx_u) : mx_u;
        my_abs = my_u[15] ? (16'd0 - my_u) : my_u;

        if (bucket_cols_reg == 7'd0)
            cols = 7'd1;
        else if (bucket_cols_reg > mvga_pkg::GRID_MAX)
            cols = mvga_pkg::GRID_MAX;
        else
            cols = bucket_cols_reg;

        if (bucket_rows_reg == 7'd0)
            rows = 7'd1;
        else if (bucket_rows_reg > mvga_pkg::GRID_MAX)
            rows = mvga_pkg::GRID_MAX;
        else
            rows = bucket_rows_reg;

        mot       = sq_x_reg + sq_y_reg;
        in_window = (mot >= min_move_sq_reg) && (mot <= max_move_sq_reg);
        grid_idx  = 13'(cols) * 13'(by_reg) + 13'(bx_reg);
        grid_wide = 32'(grid_idx);
        idx_wide  = 32'(item_reg.bkt_sel);
        grid_ok   = (grid_wide < 32'(MAX_BUCKETS));
        idx_ok    = (idx_wide < 32'(MAX_BUCKETS));
        rd_addr   = (item_reg.mode == mvga_pkg::MODE_VECTOR) ? grid_wide[ADDR_W-1:0]
                                                            : idx_wide[ADDR_W-1:0];

        sx_abs = sx_reg[23] ? (24'd0 - sx_reg) : sx_reg;
        sy_abs = sy_reg[23] ? (24'd0 - sy_reg) : sy_reg;
        thr    = 32'(ref_value_reg) << THR_SHIFT;
        div_dvs = 17'(cnt_reg) + 17'd1;
    end

    // bucket update for a counted vector
    always_comb
    begin
        upd        = rd;
        upd.count  = (rd.count == mvga_pkg::COUNT_MAX) ? rd.count : rd.count + 16'd1;
        upd.sum_x  = sat_add(rd.sum_x, item_reg.vec_dx);
        upd.sum_y  = sat_add(rd.sum_y, item_reg.vec_dy);
    end

    // sequencer: next state, RAM access and result
    always_comb
    begin
        state_next        = state_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = rd;
        ram_re            = 1'b0;
        div_start         = 1'b0;

        case (state_reg)
            mvga_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == ADDR_W'(MAX_BUCKETS - 1))
                    state_next = mvga_pkg::ST_IDLE;
            end
            mvga_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = mvga_pkg::ST_CALC;
            end
            mvga_pkg::ST_CALC:
            begin
                state_next = mvga_pkg::ST_ADDR;
            end
            mvga_pkg::ST_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = mvga_pkg::ST_RMW;
            end
            mvga_pkg::ST_RMW:
            begin
                result_next       = '0;
                result_valid_next = 1'b1;
                state_next        = mvga_pkg::ST_IDLE;
                case (item_reg.mode)
                    mvga_pkg::MODE_VECTOR:
                    begin
                        if (vec_ok_reg && rd.weight != 10'd0)
                        begin
                            ram_we               = 1'b1;
                            ram_wdata            = upd;
                            result_next.accepted = 1'b1;
                        end
                    end
                    mvga_pkg::MODE_WEIGHT:
                    begin
                        if (idx_ok)
                        begin
                            ram_we           = 1'b1;
                            ram_wdata        = rd;
                            ram_wdata.weight = item_reg.mask_weight;
                        end
                    end
                    mvga_pkg::MODE_READ:
                    begin
                        if (idx_ok)
                        begin
                            ram_we            = 1'b1;
                            ram_wdata         = '0;
                            ram_wdata.weight  = rd.weight;
                            result_valid_next = 1'b0;
                            state_next        = mvga_pkg::ST_SQ;
                        end
                    end
                    default: ;
                endcase
            end
            mvga_pkg::ST_SQ:
            begin
                state_next = mvga_pkg::ST_MAG;
            end
            mvga_pkg::ST_MAG:
            begin
                state_next = mvga_pkg::ST_NUM;
            end
            mvga_pkg::ST_NUM:
            begin
                state_next = mvga_pkg::ST_DIVGO;
            end
            mvga_pkg::ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = mvga_pkg::ST_DIV;
            end
            mvga_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    result_next.accepted     = 1'b0;
                    result_next.hit          = (div_quo >= mvga_pkg::DVD_W'(thr)) &&
                                               (cnt_reg >= min_vector_count_reg);
                    result_next.score        = (div_quo[mvga_pkg::DVD_W-1:32] != '0) ?
                                               32'hFFFF_FFFF : div_quo[31:0];
                    result_next.vector_count = cnt_reg;
                    result_valid_next        = 1'b1;
                    state_next               = mvga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvga_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mvga_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            if (state_reg == mvga_pkg::ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // payload registers, loaded per step
    always_ff @(posedge clk)
    begin
        if (state_reg == mvga_pkg::ST_IDLE && start)
            item_reg <= item;
        if (state_reg == mvga_pkg::ST_CALC)
        begin
            sq_x_reg <= 32'(mx_abs) * 32'(mx_abs);
            sq_y_reg <= 32'(my_abs) * 32'(my_abs);
            bx_reg   <= clamp_axis(item_reg.dst_x, cols);
            by_reg   <= clamp_axis(item_reg.dst_y, rows);
        end
        if (state_reg == mvga_pkg::ST_ADDR)
        begin
            vec_ok_reg <= in_window && grid_ok;
            addr_reg   <= rd_addr;
        end
        if (state_reg == mvga_pkg::ST_RMW)
        begin
            sx_reg  <= rd.sum_x;
            sy_reg  <= rd.sum_y;
            wt_reg  <= rd.weight;
            cnt_reg <= rd.count;
        end
        if (state_reg == mvga_pkg::ST_SQ)
        begin
            msq_x_reg <= mvga_pkg::MAG_W'(sx_abs) * mvga_pkg::MAG_W'(sx_abs);
            msq_y_reg <= mvga_pkg::MAG_W'(sy_abs) * mvga_pkg::MAG_W'(sy_abs);
        end
        if (state_reg == mvga_pkg::ST_MAG)
            mag_reg <= msq_x_reg + msq_y_reg;
        if (state_reg == mvga_pkg::ST_NUM)
            num_reg <= mvga_pkg::NUM_W'(mag_reg) * mvga_pkg::NUM_W'(wt_reg);
    end

    assign busy         = (state_reg != mvga_pkg::ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a taken item keeps the block busy until its result
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking an item");

    // each result beat is a single-cycle strobe
    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mvga_pkg::ST_DIV))
        else $error("divider done outside wait state");

    // RAM is written only by the clearing pass or the write-back step
    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mvga_pkg::ST_CLEAR || state_reg == mvga_pkg::ST_RMW))
        else $error("bucket RAM written in unexpected state");

endmodule

// ----- verif/motion_vector_grid_accumulator_core_tb.sv -----
module motion_vector_grid_accumulator_core_tb;

    localparam int          BUCKETS     = 4096;
    localparam int          BUCKET_BITS = 5;
    localparam logic [1:0]  MODE_NONE   = 2'd3;
    localparam int          TARGET_ITEMS = 950;
    localparam int          CYCLE_LIMIT  = 600000;

    // bucket grid predictor and the answers it still expects
    class bucket_grid_scoreboard;
        logic [31:0] min_move_sq;
        logic [31:0] max_move_sq;
        logic [15:0] min_count;
        logic [15:0] ref_val;
        logic [6:0]  cols;
        logic [6:0]  rows;
        logic [15:0] cnt [BUCKETS];
        int          sum_x [BUCKETS];
        int          sum_y [BUCKETS];
        logic [9:0]  wt [BUCKETS];
        mvga_pkg::result_t answers [$];
        int          errors;

        function new();
            min_move_sq = mvga_pkg::RST_MIN_MOVE_SQ;
            max_move_sq = mvga_pkg::RST_MAX_MOVE_SQ;
            min_count   = mvga_pkg::RST_MIN_VECTOR_COUNT;
            ref_val     = mvga_pkg::RST_REF_VALUE;
            cols        = mvga_pkg::RST_BUCKET_COLS;
            rows        = mvga_pkg::RST_BUCKET_ROWS;
            errors      = 0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                cnt[i]   = '0;
                sum_x[i] = 0;
                sum_y[i] = 0;
                wt[i]    = '0;
            end
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                mvga_pkg::CFG_MIN_MOVE_SQ:      min_move_sq = data;
                mvga_pkg::CFG_MAX_MOVE_SQ:      max_move_sq = data;
                mvga_pkg::CFG_MIN_VECTOR_COUNT: min_count   = data[15:0];
                mvga_pkg::CFG_REF_VALUE:        ref_val     = data[15:0];
                mvga_pkg::CFG_BUCKET_COLS:      cols        = data[6:0];
                mvga_pkg::CFG_BUCKET_ROWS:      rows        = data[6:0];
                default: ;
            endcase
        endfunction

        function int grid_dim(logic [6:0] v);
            if (v == 0)
                return 1;
            if (v > 64)
                return 64;
            return int'(v);
        endfunction

        function int clamp_axis(int p, int dim);
            int b;
            if (p < 0)
                return 0;
            b = p >> BUCKET_BITS;
            return (b > dim - 1) ? dim - 1 : b;
        endfunction

        function int sat_sum(int a, int b);
            int s;
            s = a + b;
            if (s > 8388607)
                return 8388607;
            if (s < -8388608)
                return -8388608;
            return s;
        endfunction

        function void note_item(mvga_pkg::item_t it);
            mvga_pkg::result_t  e;
            int                 mx, my, ax, ay, cw, rh, g;
            longint unsigned    mot, ux, uy, mag, num, den, raw, thr;
            e = '0;
            if (it.mode == mvga_pkg::MODE_VECTOR)
            begin
                mx  = int'(it.vec_dx);
                my  = int'(it.vec_dy);
                ax  = (mx < 0) ? -mx : mx;
                ay  = (my < 0) ? -my : my;
                mot = longint'(ax) * ax + longint'(ay) * ay;
                if (mot >= longint'(min_move_sq) && mot <= longint'(max_move_sq))
                begin
                    cw = grid_dim(cols);
                    rh = grid_dim(rows);
                    g  = cw * clamp_axis(int'(it.dst_y), rh) + clamp_axis(int'(it.dst_x), cw);
                    if (g < BUCKETS && wt[g] != 0)
                    begin
                        if (cnt[g] != mvga_pkg::COUNT_MAX)
                            cnt[g]++;
                        sum_x[g]   = sat_sum(sum_x[g], mx);
                        sum_y[g]   = sat_sum(sum_y[g], my);
                        e.accepted = 1'b1;
                    end
                end
            end
            else if (it.mode == mvga_pkg::MODE_WEIGHT)
            begin
                wt[it.bkt_sel] = it.mask_weight;
            end
            else if (it.mode == mvga_pkg::MODE_READ)
            begin
                g   = int'(it.bkt_sel);
                ux  = longint'((sum_x[g] < 0) ? -sum_x[g] : sum_x[g]);
                uy  = longint'((sum_y[g] < 0) ? -sum_y[g] : sum_y[g]);
                mag = ux * ux + uy * uy;
                num = mag * longint'(wt[g]);
                den = 256 * (longint'(cnt[g]) + 1);
                raw = num / den;
                thr = longint'(ref_val) << (2 * BUCKET_BITS - 3);
                e.vector_count = cnt[g];
                e.hit   = (raw >= thr && cnt[g] >= min_count);
                e.score = (raw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : raw[31:0];
                cnt[g]   = '0;
                sum_x[g] = 0;
                sum_y[g] = 0;
            end
            answers = {answers, e};
        endfunction

        function void check_result(mvga_pkg::result_t r);
            mvga_pkg::result_t e;
            if (answers.size() == 0)
            begin
                $error("result beat with no item pending");
                errors++;
                return;
            end
            e = answers.pop_front();
            if (r.accepted !== e.accepted)
            begin
                $error("accepted: expected %0d, actual %0d", e.accepted, r.accepted);
                errors++;
            end
            if (r.hit !== e.hit)
            begin
                $error("hit: expected %0d, actual %0d", e.hit, r.hit);
                errors++;
            end
            if (r.score !== e.score)
            begin
                $error("score: expected %0d, actual %0d", e.score, r.score);
                errors++;
            end
            if (r.vector_count !== e.vector_count)
            begin
                $error("vector_count: expected %0d, actual %0d", e.vector_count,
                       r.vector_count);
                errors++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    mvga_pkg::item_t                        item;
    logic                                   result_valid;
    mvga_pkg::result_t                      result;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [mvga_pkg::CFG_IDX_W-1:0]         cfg_index;
    logic [31:0]                            cfg_data;

    bucket_grid_scoreboard  board;
    int                     items_sent;
    bit                     idle_on;

    motion_vector_grid_accumulator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(result);
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** motion_vector_grid_accumulator_core: FAILED **");
        $finish;
    end

    function automatic mvga_pkg::item_t make_item(logic [1:0] md, int dx, int dy, int mx,
                                                  int my, int idx, int w);
        mvga_pkg::item_t it;
        it.mode         = md;
        it.dst_x        = 16'(dx);
        it.dst_y        = 16'(dy);
        it.vec_dx       = 16'(mx);
        it.vec_dy       = 16'(my);
        it.bkt_sel      = 12'(idx);
        it.mask_weight  = 10'(w);
        return it;
    endfunction

    // one item beat, then a random gap
    task automatic send_item(mvga_pkg::item_t it);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(it);
        items_sent++;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, data);
    endtask

    task automatic write_grid_config(logic [31:0] lo, logic [31:0] hi, int minc, int rv,
                                     int c, int r);
        cfg_write(mvga_pkg::CFG_MIN_MOVE_SQ, lo);
        cfg_write(mvga_pkg::CFG_MAX_MOVE_SQ, hi);
        cfg_write(mvga_pkg::CFG_MIN_VECTOR_COUNT, 32'(minc));
        cfg_write(mvga_pkg::CFG_REF_VALUE, 32'(rv));
        cfg_write(mvga_pkg::CFG_BUCKET_COLS, 32'(c));
        cfg_write(mvga_pkg::CFG_BUCKET_ROWS, 32'(r));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop issuing and wait until every answer is back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic draw_motion(output int mx, output int my);
        int lim;
        case ($urandom_range(0, 9))
            0, 1, 2: lim = 20;
            3, 4, 5, 6: lim = 400;
            7: lim = 700;
            8: lim = 32767;
            default: lim = 0;
        endcase
        if (lim == 0)
        begin
            mx = $urandom_range(0, 1) ? -32768 : 32767;
            my = $urandom_range(0, 1) ? -32768 : 32767;
        end
        else
        begin
            mx = int'($urandom_range(0, 2 * lim)) - lim;
            my = int'($urandom_range(0, 2 * lim)) - lim;
        end
    endtask

    // random item of any mode, its fields mostly over their whole ranges
    task automatic send_noise();
        mvga_pkg::item_t it;
        int    pick;
        int    mx;
        int    my;
        it   = make_item(mvga_pkg::MODE_VECTOR, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 4095), $urandom_range(0, 768));
        pick = $urandom_range(0, 7);
        if (pick >= 3 && pick <= 4)
            it.mode = mvga_pkg::MODE_WEIGHT;
        else if (pick >= 5 && pick <= 6)
            it.mode = mvga_pkg::MODE_READ;
        else if (pick == 7)
            it.mode = MODE_NONE;
        if (it.mode == mvga_pkg::MODE_VECTOR && $urandom_range(0, 1))
        begin
            draw_motion(mx, my);
            it.vec_dx = 16'(mx);
            it.vec_dy = 16'(my);
        end
        if (it.mode == mvga_pkg::MODE_WEIGHT && $urandom_range(0, 3) == 0)
            it.mask_weight = '0;
        send_item(it);
    endtask

    // optional weight load, a few vectors into that bucket, then read and clear
    task automatic send_bucket_sequence();
        int cw, rh, col, row, g, n, dx, dy, mx, my;
        cw  = board.grid_dim(board.cols);
        rh  = board.grid_dim(board.rows);
        col = $urandom_range(0, cw - 1);
        row = $urandom_range(0, rh - 1);
        g   = row * cw + col;
        if ($urandom_range(0, 4) != 0)
            send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, g, $urandom_range(1, 768)));
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            dx = (col << BUCKET_BITS) + $urandom_range(0, 31);
            dy = (row << BUCKET_BITS) + $urandom_range(0, 31);
            if (col == cw - 1 && $urandom_range(0, 3) == 0)
                dx = $urandom_range(dx, 32767);
            if (row == rh - 1 && $urandom_range(0, 3) == 0)
                dy = $urandom_range(dy, 32767);
            if (col == 0 && $urandom_range(0, 3) == 0)
                dx = -int'($urandom_range(1, 32768));
            if (row == 0 && $urandom_range(0, 3) == 0)
                dy = -int'($urandom_range(1, 32768));
            draw_motion(mx, my);
            send_item(make_item(mvga_pkg::MODE_VECTOR, dx, dy, mx, my, $urandom,
                                $urandom_range(0, 768)));
        end
        send_item(make_item(mvga_pkg::MODE_READ, $urandom, $urandom, $urandom, $urandom, g, 0));
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                send_noise();
            else
                send_bucket_sequence();
        end
    endtask

    task automatic write_random_config();
        logic [31:0] lo, hi;
        int          c, r, rv;
        lo = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(0, 100));
        hi = ($urandom_range(0, 3) == 0) ? 32'h8000_0000 : 32'($urandom_range(2000, 600000));
        rv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 64);
        c  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        r  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        write_grid_config(lo, hi, $urandom_range(0, 5), rv, c, r);
    endtask

    initial
    begin
        board      = new();
        items_sent = 0;
        idle_on    = 1'b1;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // clearing pass after reset
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: window edges, clamping, zero weight, reads, idle mode
        write_grid_config(32'd4, 32'd512000, 2, 16, 20, 15);
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 0, 256));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 5, 5, 2, 0, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, -32768, -32768, 1, 1, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, -1, -1, -400, -580, 0, 0));
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 299, 768));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 32767, 32767, -512, -480, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 32767, 32767, 0, 0, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 100, 100, 10, 10, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 299, 0));
        send_item(make_item(MODE_NONE, -1, -1, -1, -1, 4095, 768));
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 4095, 768));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 4095, 0));
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 63, 1));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 100, 100, 700, 100, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 100, 100, 700, 100, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 63, 0));
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 63, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 100, 100, 700, 100, 0, 0));
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 5, 768));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 160, 0, 640, 320, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 160, 0, 640, 321, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 160, 0, -640, -320, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 5, 0));
        drain();

        // widest window, full grid: drive one bucket's sums into saturation
        write_grid_config(32'd0, 32'h8000_0000, 0, 0, 64, 64);
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 10 * 64 + 7, 768));
        repeat (260)
            send_item(make_item(mvga_pkg::MODE_VECTOR, 7 * 32 + 3, 10 * 32 + 3, -32768, 32767,
                                0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 10 * 64 + 7, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 7 * 32 + 3, 10 * 32 + 3, -32768, -32768,
                            0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 7 * 32 + 3, 10 * 32 + 3, 32767, 32767,
                            0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 10 * 64 + 7, 0));
        run_random(120);
        drain();

        // single bucket, window pinned to its top, thresholds at maximum
        write_grid_config(32'h8000_0000, 32'h8000_0000, 65535, 65535, 1, 1);
        send_item(make_item(mvga_pkg::MODE_WEIGHT, 0, 0, 0, 0, 0, 512));
        repeat (3)
            send_item(make_item(mvga_pkg::MODE_VECTOR, 5000, -5000, -32768, -32768, 0, 0));
        send_item(make_item(mvga_pkg::MODE_VECTOR, 0, 0, 32767, 32767, 0, 0));
        send_item(make_item(mvga_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
        run_random(40);
        drain();

        // zero columns act as one, oversize rows act as 64
        write_grid_config(32'd4, 32'd512000, 2, 16, 0, 127);
        run_random(80);

        while (items_sent < TARGET_ITEMS)
        begin
            drain();
            write_random_config();
            run_random((TARGET_ITEMS - items_sent < 120) ? TARGET_ITEMS - items_sent : 120);
        end

        drain();
        repeat (64) @(posedge clk);
        if (board.pending() != 0)
            $error("%0d results never arrived", board.pending());
        if (board.errors == 0 && board.pending() == 0)
            $display("** motion_vector_grid_accumulator_core: PASSED **");
        else
            $display("** motion_vector_grid_accumulator_core: FAILED **");
        $finish;
    end

endmodule
